@@ rtl/core/oaht_pkg.sv @@
// ============================================================================
// oaht_pkg
// Shared widths, codes and types of the open-addressing hash table.
// ============================================================================
`default_nettype none

package oaht_pkg;

    // Field widths fixed by the channel definitions.
    localparam int KIND_W        = 2;
    localparam int KEY_W         = 64;
    localparam int HASH_W        = 64;
    localparam int INDEX_W       = 10;
    localparam int STATUS_W      = 2;
    localparam int ENTRIES_W     = 11;
    localparam int SLOT_BITS_W   = 4;

    // Defaults of the top-level parameters.
    localparam int LOG2_MAX_SLOTS_DEF = 10;
    localparam int KEY_WIDTH_DEF      = 64;

    // Probing constants.
    localparam int MIN_SLOT_BITS = 2;
    localparam int PERTURB_SHIFT = 5;
    localparam int PROBE_SLACK   = 13;

    localparam logic [SLOT_BITS_W-1:0] SLOT_BITS_RESET = 4'd2;

    // Epoch tag kept with every slot; a slot is occupied when its tag equals
    // the current epoch. Tag zero is never a live epoch.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [INDEX_W-1:0]   found_index;
        logic [ENTRIES_W-1:0] entries_used;
    } res_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/oaht_if.sv @@
// ============================================================================
// oaht_if
// Valid/ready channel interfaces of the hash table: request, response and
// configuration write.
// ============================================================================
`default_nettype none

interface oaht_in_if import oaht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
    logic [HASH_W-1:0]   hash;
    logic [INDEX_W-1:0]  store_index;

    modport source (output valid, kind, key, hash, store_index, input ready);
    modport sink   (input valid, kind, key, hash, store_index, output ready);
endinterface

interface oaht_out_if import oaht_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [INDEX_W-1:0]   found_index;
    logic [ENTRIES_W-1:0] entries_used;

    modport source (output valid, status, found_index, entries_used, input ready);
    modport sink   (input valid, status, found_index, entries_used, output ready);
endinterface

interface oaht_cfg_if import oaht_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SLOT_BITS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/oaht_slot_mem.sv @@
// ============================================================================
// oaht_slot_mem
// Slot store: one write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module oaht_slot_mem import oaht_pkg::*; #(
    parameter int LOG2_MAX_SLOTS = LOG2_MAX_SLOTS_DEF,
    parameter int KEY_WIDTH      = KEY_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire mem_ctrl_t                 ctrl,
    input  wire logic [LOG2_MAX_SLOTS-1:0] rd_addr,
    input  wire logic [LOG2_MAX_SLOTS-1:0] wr_addr,
    input  wire logic [EPOCH_W-1:0]        wr_tag,
    input  wire logic [KEY_WIDTH-1:0]      wr_key,
    input  wire logic [HASH_W-1:0]         wr_hash,
    input  wire logic [INDEX_W-1:0]        wr_index,
    output logic      [EPOCH_W-1:0]        rd_tag,
    output logic      [KEY_WIDTH-1:0]      rd_key,
    output logic      [HASH_W-1:0]         rd_hash,
    output logic      [INDEX_W-1:0]        rd_index
);

    localparam int DEPTH   = 1 << LOG2_MAX_SLOTS;
    localparam int ENTRY_W = EPOCH_W + KEY_WIDTH + HASH_W + INDEX_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= {wr_tag, wr_key, wr_hash, wr_index};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign {rd_tag, rd_key, rd_hash, rd_index} = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/oaht_ctrl.sv @@
// ============================================================================
// oaht_ctrl
// Probe sequencer: walks the perturbation probe chain through the slot
// store, commits inserts, tracks the epoch and runs the clearing sweep.
// ============================================================================
`default_nettype none

module oaht_ctrl import oaht_pkg::*; #(
    parameter int LOG2_MAX_SLOTS = LOG2_MAX_SLOTS_DEF,
    parameter int KEY_WIDTH      = KEY_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    oaht_in_if.sink                        req,
    input  wire logic [SLOT_BITS_W-1:0]    slot_bits,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output res_t                           res,
    output mem_ctrl_t                      mem_ctrl,
    output logic      [LOG2_MAX_SLOTS-1:0] mem_rd_addr,
    output logic      [LOG2_MAX_SLOTS-1:0] mem_wr_addr,
    output logic      [EPOCH_W-1:0]        mem_wr_tag,
    output logic      [KEY_WIDTH-1:0]      mem_wr_key,
    output logic      [HASH_W-1:0]         mem_wr_hash,
    output logic      [INDEX_W-1:0]        mem_wr_index,
    input  wire logic [EPOCH_W-1:0]        mem_rd_tag,
    input  wire logic [KEY_WIDTH-1:0]      mem_rd_key,
    input  wire logic [HASH_W-1:0]         mem_rd_hash,
    input  wire logic [INDEX_W-1:0]        mem_rd_index
);

    localparam int L       = LOG2_MAX_SLOTS;
    localparam int PW      = LOG2_MAX_SLOTS + 5;
    localparam int BITS_W  = 5;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [L:0]         used_reg, used_next;
    logic [L-1:0]       sweep_reg, sweep_next;

    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [HASH_W-1:0]  perturb_reg, perturb_next;
    logic [L-1:0]       slot_reg, slot_next;
    logic [L-1:0]       mask_reg, mask_next;
    logic [PW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]      lim_reg, lim_next;
    res_t               res_reg, res_next;

    logic [BITS_W-1:0]  eff_bits;
    logic [L-1:0]       cur_mask;
    logic [PW-1:0]      cur_lim;
    logic [HASH_W-1:0]  perturb_shr;
    logic [L-1:0]       step_slot;
    logic               slot_live;
    logic               slot_hit;
    logic               accept;

    // Slot bits clamped to the supported range.
    always_comb
    begin
        eff_bits = {1'b0, slot_bits};
        if (eff_bits < BITS_W'(MIN_SLOT_BITS))
        begin
            eff_bits = BITS_W'(MIN_SLOT_BITS);
        end
        else if (eff_bits > BITS_W'(L))
        begin
            eff_bits = BITS_W'(L);
        end
    end

    assign cur_mask = {L{1'b1}} >> (BITS_W'(L) - eff_bits);
    assign cur_lim  = (PW'(1) << eff_bits) + PW'(PROBE_SLACK);

    // Next probe: 5 * slot + 1 + perturb, formed as a shift and add.
    assign perturb_shr = perturb_reg >> PERTURB_SHIFT;
    assign step_slot   = ((slot_reg << 2) + slot_reg + L'(1) + perturb_shr[L-1:0]) & mask_reg;

    assign slot_live = (mem_rd_tag == epoch_reg);
    assign slot_hit  = slot_live && (mem_rd_hash == hash_reg) && (mem_rd_key == key_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        epoch_next   = epoch_reg;
        used_next    = used_reg;
        sweep_next   = sweep_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        hash_next    = hash_reg;
        idx_next     = idx_reg;
        perturb_next = perturb_reg;
        slot_next    = slot_reg;
        mask_next    = mask_reg;
        cnt_next     = cnt_reg;
        lim_next     = lim_reg;
        res_next     = res_reg;

        mem_ctrl     = '0;
        mem_rd_addr  = slot_reg;
        mem_wr_addr  = slot_reg;
        mem_wr_tag   = epoch_reg;
        mem_wr_key   = key_reg;
        mem_wr_hash  = hash_reg;
        mem_wr_index = idx_reg;

        unique case (state_reg) inside
            S_INIT, S_SWEEP:
            begin
                mem_ctrl.wr_en = 1'b1;
                mem_wr_addr    = sweep_reg;
                mem_wr_tag     = EPOCH_NONE;
                mem_wr_key     = '0;
                mem_wr_hash    = '0;
                mem_wr_index   = '0;
                sweep_next     = sweep_reg + L'(1);
                if (&sweep_reg)
                begin
                    epoch_next = EPOCH_FIRST;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_RESP;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = req.kind;
                    res_next  = '{status: STATUS_OK, found_index: '0,
                                  entries_used: ENTRIES_W'(used_reg)};
                    unique case (req.kind) inside
                        KIND_CLEAR:
                        begin
                            used_next             = '0;
                            res_next.entries_used = '0;
                            if (epoch_reg == EPOCH_LAST)
                            begin
                                sweep_next = '0;
                                state_next = S_SWEEP;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + EPOCH_W'(1);
                                state_next = S_RESP;
                            end
                        end
                        KIND_INSERT, KIND_LOOKUP:
                        begin
                            key_next       = req.key[KEY_WIDTH-1:0];
                            hash_next      = req.hash;
                            idx_next       = req.store_index;
                            perturb_next   = req.hash;
                            slot_next      = req.hash[L-1:0] & cur_mask;
                            mask_next      = cur_mask;
                            lim_next       = cur_lim;
                            cnt_next       = '0;
                            mem_ctrl.rd_en = 1'b1;
                            mem_rd_addr    = req.hash[L-1:0] & cur_mask;
                            state_next     = S_PROBE;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (!slot_live)
                begin
                    state_next = S_RESP;
                    if (kind_reg == KIND_INSERT)
                    begin
                        mem_ctrl.wr_en        = 1'b1;
                        used_next             = used_reg + (L+1)'(1);
                        res_next.entries_used = ENTRIES_W'(used_reg + (L+1)'(1));
                    end
                    else
                    begin
                        res_next.status = STATUS_MISS;
                    end
                end
                else if ((kind_reg == KIND_LOOKUP) && slot_hit)
                begin
                    res_next.found_index = mem_rd_index;
                    state_next           = S_RESP;
                end
                else if (cnt_reg + PW'(1) == lim_reg)
                begin
                    res_next.status = (kind_reg == KIND_INSERT) ? STATUS_FULL : STATUS_MISS;
                    state_next      = S_RESP;
                end
                else
                begin
                    perturb_next   = perturb_shr;
                    slot_next      = step_slot;
                    cnt_next       = cnt_reg + PW'(1);
                    mem_ctrl.rd_en = 1'b1;
                    mem_rd_addr    = step_slot;
                end
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            epoch_reg <= EPOCH_FIRST;
            used_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
            used_reg  <= used_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        hash_reg    <= hash_next;
        idx_reg     <= idx_next;
        perturb_reg <= perturb_next;
        slot_reg    <= slot_next;
        mask_reg    <= mask_next;
        cnt_reg     <= cnt_next;
        lim_reg     <= lim_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/open_addressing_hash_table_top.sv @@
// ============================================================================
// open_addressing_hash_table_top
// Insert-only open-addressing hash table with perturbation probing.
// ============================================================================
// Each request transaction clears the table, inserts a key with its hash and
// stored index, or looks a key up, and yields exactly one response
// transaction. Probing starts at the hash masked to the table size and steps
// to (5 * slot + 1 + perturb) masked, perturb being the hash shifted right by
// five more bits at each step. The slots live in one synchronous memory with
// a single read port and a single write port; each read is issued in the
// cycle that inspects the previous read's data. An insert or lookup passes
// through the accepting cycle, which issues the first read, its probes and
// the response state; unknown kinds, and clears that need no sweep, go from
// the accepting cycle straight to the response state. Occupancy is kept as
// an eight-bit epoch tag in every slot, so a clear is a single increment;
// after reset, and on every 255th clear, a sweep rewrites the tag of all
// 2^LOG2_MAX_SLOTS slots (1024 by default), accepting no request meanwhile.
// The slot_bits register may be written at any time the block is idle; values
// outside [2, LOG2_MAX_SLOTS] are clamped. A lookup gives up after the slot
// count plus thirteen probes and reports a miss; an insert that finds no free
// slot in that bound reports the table as full. The response register lets a
// new request be accepted while the previous response has not been taken.
// ============================================================================
`default_nettype none

module open_addressing_hash_table_top import oaht_pkg::*; #(
    parameter int LOG2_MAX_SLOTS = LOG2_MAX_SLOTS_DEF,
    parameter int KEY_WIDTH      = KEY_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    oaht_in_if.sink   req,
    oaht_out_if.source rsp,
    oaht_cfg_if.sink  cfg
);

    logic [SLOT_BITS_W-1:0]    slot_bits_reg;
    logic                      out_valid_reg, out_valid_next;
    res_t                      out_reg;

    logic                      res_valid;
    logic                      res_ready;
    res_t                      res;

    mem_ctrl_t                 mem_ctrl;
    logic [LOG2_MAX_SLOTS-1:0] mem_rd_addr;
    logic [LOG2_MAX_SLOTS-1:0] mem_wr_addr;
    logic [EPOCH_W-1:0]        mem_wr_tag;
    logic [KEY_WIDTH-1:0]      mem_wr_key;
    logic [HASH_W-1:0]         mem_wr_hash;
    logic [INDEX_W-1:0]        mem_wr_index;
    logic [EPOCH_W-1:0]        mem_rd_tag;
    logic [KEY_WIDTH-1:0]      mem_rd_key;
    logic [HASH_W-1:0]         mem_rd_hash;
    logic [INDEX_W-1:0]        mem_rd_index;

    // The configuration register is always writable; the block only samples
    // it when a request is accepted.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bits_reg <= SLOT_BITS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            slot_bits_reg <= cfg.data;
        end
    end

    // Response register: the sequencer hands over a result whenever the
    // register is empty or is being emptied in the same cycle.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.found_index  = out_reg.found_index;
    assign rsp.entries_used = out_reg.entries_used;

    oaht_ctrl #(
        .LOG2_MAX_SLOTS (LOG2_MAX_SLOTS),
        .KEY_WIDTH      (KEY_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .slot_bits    (slot_bits_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_ctrl     (mem_ctrl),
        .mem_rd_addr  (mem_rd_addr),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_tag   (mem_wr_tag),
        .mem_wr_key   (mem_wr_key),
        .mem_wr_hash  (mem_wr_hash),
        .mem_wr_index (mem_wr_index),
        .mem_rd_tag   (mem_rd_tag),
        .mem_rd_key   (mem_rd_key),
        .mem_rd_hash  (mem_rd_hash),
        .mem_rd_index (mem_rd_index)
    );

    // An insert writes its slot in its last probe cycle, and the next request
    // can issue its first read only after the response state, so reads and
    // writes of one slot never overlap.
    oaht_slot_mem #(
        .LOG2_MAX_SLOTS (LOG2_MAX_SLOTS),
        .KEY_WIDTH      (KEY_WIDTH)
    ) u_slot_mem (
        .clk      (clk),
        .ctrl     (mem_ctrl),
        .rd_addr  (mem_rd_addr),
        .wr_addr  (mem_wr_addr),
        .wr_tag   (mem_wr_tag),
        .wr_key   (mem_wr_key),
        .wr_hash  (mem_wr_hash),
        .wr_index (mem_wr_index),
        .rd_tag   (mem_rd_tag),
        .rd_key   (mem_rd_key),
        .rd_hash  (mem_rd_hash),
        .rd_index (mem_rd_index)
    );

endmodule

`default_nettype wire
